// File: rtl/tbf_pkg.sv
// Shared types and constants of the tape block framer.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package tbf_pkg;

	// width of the block length word
	localparam int LEN_BITS = 16;

	// largest length per layout, one bit wider so that the compare cannot wrap
	localparam logic [LEN_BITS:0] LEN_MAX_RAW  = (LEN_BITS+1)'((1 << LEN_BITS) - 1);
	localparam logic [LEN_BITS:0] LEN_MAX_FLAG = (LEN_BITS+1)'((1 << LEN_BITS) - 3);

	// block layouts
	localparam logic [1:0] MODE_RAW      = 2'd0;
	localparam logic [1:0] MODE_HEADLESS = 2'd1;
	localparam logic [1:0] MODE_BASIC    = 2'd2;
	localparam logic [1:0] MODE_CODE     = 2'd3;

	// item actions
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_DATA  = 1'b1;

	// result status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_LONG = 2'd1;
	localparam logic [1:0] ST_SURPLUS  = 2'd2;
	localparam logic [1:0] ST_EARLY    = 2'd3;

	// register indexes
	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_LENGTH    = 3'd1;
	localparam logic [2:0] REG_START     = 3'd2;
	localparam logic [2:0] REG_AUTOSTART = 3'd3;
	localparam logic [2:0] REG_NAME_LO   = 3'd4;
	localparam logic [2:0] REG_NAME_HI   = 3'd5;

	// kinds of output run
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_FAIL  = 2'd2;

	// positions in the start run; header block first, then the data block prefix
	localparam logic [4:0] POS_HDR_LEN_LO = 5'd0;
	localparam logic [4:0] POS_HDR_LEN_HI = 5'd1;
	localparam logic [4:0] POS_HDR_FLAG   = 5'd2;
	localparam logic [4:0] POS_HDR_TYPE   = 5'd3;
	localparam logic [4:0] POS_NAME_FIRST = 5'd4;
	localparam logic [4:0] POS_NAME_LAST  = 5'd13;
	localparam logic [4:0] POS_DLEN_LO    = 5'd14;
	localparam logic [4:0] POS_DLEN_HI    = 5'd15;
	localparam logic [4:0] POS_W1_LO      = 5'd16;
	localparam logic [4:0] POS_W1_HI      = 5'd17;
	localparam logic [4:0] POS_W2_LO      = 5'd18;
	localparam logic [4:0] POS_W2_HI      = 5'd19;
	localparam logic [4:0] POS_HDR_SUM    = 5'd20;
	localparam logic [4:0] POS_LEN_LO     = 5'd21;
	localparam logic [4:0] POS_LEN_HI     = 5'd22;
	localparam logic [4:0] POS_FLAG       = 5'd23;
	localparam logic [4:0] POS_EMPTY_SUM  = 5'd24;

	localparam logic [7:0] HDR_BLOCK_LEN = 8'd19;
	localparam logic [7:0] FLAG_HEADER   = 8'h00;
	localparam logic [7:0] FLAG_DATA     = 8'hFF;
	localparam logic [7:0] TYPE_BASIC    = 8'd0;
	localparam logic [7:0] TYPE_CODE     = 8'd3;
	localparam logic [15:0] NO_AUTOSTART = 16'h8000;
	localparam int NAME_BYTES = 10;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] data_length;
		logic [15:0] start_value;
		logic        autostart;
		logic [15:0] name_high;
		logic [63:0] name_low;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/tbf_if.sv
// Channel interfaces of the tape block framer: item in, result out, register write.
// Depends on nothing.
`default_nettype none

interface tbf_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;
	modport source (output valid, action, data_byte, input ready);
	modport sink (input valid, action, data_byte, output ready);
endinterface

interface tbf_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic [1:0] status;
	modport source (output valid, out_byte, last_of_run, status, input ready);
	modport sink (input valid, out_byte, last_of_run, status, output ready);
endinterface

interface tbf_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/tbf_prefix.sv
// Byte select for the start run: header block and data block prefix.
// Uses tbf_pkg (cfg_t, positions, layout codes).
`default_nettype none

module tbf_prefix (
	input  tbf_pkg::cfg_t cfg,
	input  logic [4:0]    pos,
	output logic [7:0]    pbyte
);

	logic [79:0] name_all;
	logic [3:0]  name_idx;
	logic        is_code;
	logic [7:0]  type_byte;
	logic [15:0] w1;
	logic [15:0] w2;
	logic [15:0] total;
	logic [15:0] len_word;
	logic [7:0]  name_sum;
	logic [7:0]  hdr_sum;

	assign name_all  = {cfg.name_high, cfg.name_low};
	assign name_idx  = 4'(pos - tbf_pkg::POS_NAME_FIRST);
	assign is_code   = (cfg.mode == tbf_pkg::MODE_CODE);
	assign type_byte = is_code ? tbf_pkg::TYPE_CODE : tbf_pkg::TYPE_BASIC;
	assign w1 = (is_code || cfg.autostart) ? cfg.start_value : tbf_pkg::NO_AUTOSTART;
	assign w2 = is_code ? tbf_pkg::NO_AUTOSTART : cfg.data_length;
	assign total = cfg.data_length + 16'd2;
	assign len_word = (cfg.mode == tbf_pkg::MODE_RAW) ? cfg.data_length : total;

	always_comb begin
		name_sum = '0;
		for (int i = 0; i < tbf_pkg::NAME_BYTES; i++) begin
			name_sum = name_sum ^ name_all[8*i +: 8];
		end
	end

	// header checksum covers flag (zero), type, name and the three words
	assign hdr_sum = type_byte ^ name_sum ^ cfg.data_length[7:0] ^ cfg.data_length[15:8]
		^ w1[7:0] ^ w1[15:8] ^ w2[7:0] ^ w2[15:8];

	always_comb begin
		unique case (pos)
			tbf_pkg::POS_HDR_LEN_LO: pbyte = tbf_pkg::HDR_BLOCK_LEN;
			tbf_pkg::POS_HDR_LEN_HI: pbyte = 8'd0;
			tbf_pkg::POS_HDR_FLAG:   pbyte = tbf_pkg::FLAG_HEADER;
			tbf_pkg::POS_HDR_TYPE:   pbyte = type_byte;
			tbf_pkg::POS_DLEN_LO:    pbyte = cfg.data_length[7:0];
			tbf_pkg::POS_DLEN_HI:    pbyte = cfg.data_length[15:8];
			tbf_pkg::POS_W1_LO:      pbyte = w1[7:0];
			tbf_pkg::POS_W1_HI:      pbyte = w1[15:8];
			tbf_pkg::POS_W2_LO:      pbyte = w2[7:0];
			tbf_pkg::POS_W2_HI:      pbyte = w2[15:8];
			tbf_pkg::POS_HDR_SUM:    pbyte = hdr_sum;
			tbf_pkg::POS_LEN_LO:     pbyte = len_word[7:0];
			tbf_pkg::POS_LEN_HI:     pbyte = len_word[15:8];
			tbf_pkg::POS_FLAG:       pbyte = tbf_pkg::FLAG_DATA;
			tbf_pkg::POS_EMPTY_SUM:  pbyte = tbf_pkg::FLAG_DATA;
			default: begin
				if (pos >= tbf_pkg::POS_NAME_FIRST && pos <= tbf_pkg::POS_NAME_LAST) begin
					pbyte = name_all[{name_idx, 3'b000} +: 8];
				end else begin
					pbyte = 8'd0;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/tape_block_framer.sv
// Tape block framer top level: register file, item stage and result register.
// Uses tbf_pkg, the channel interfaces of tbf_if.sv and tbf_prefix.
//
// The block turns a byte stream into tape blocks. Write the registers while idle, then send a
// start item followed by data_length data items. Every data item gives one result beat, loaded
// into the result register from the item stage once that register is free or drained; it gives
// two beats when it is the last byte of a flagged block (the byte and the XOR checksum). A
// payload streams at one byte per cycle while the result channel is ready. A start item gives
// its whole prefix as a run of beats: 2 for raw, 3 for headerless (4 for an empty block), 24
// for basic and code (25 for an empty block); the input stalls while the run drains. The rate
// is set by the single byte-wide result register: one beat leaves per cycle while the result
// channel is ready, and the next item enters in the cycle the current run hands over its last
// beat. A bad item (length over the layout's limit, surplus byte, data with no open block)
// gives one beat of zero with the status code and is dropped; last_of_run marks the final beat
// of every run. Registers are read as they stand, so a change during a block takes effect at
// once. The register channel is always ready; writes to unknown indexes are ignored.
`default_nettype none

module tape_block_framer (
	input  logic                clk,
	input  logic                arst_n,
	tbf_item_if.sink            items,
	tbf_result_if.source        results,
	tbf_cfg_if.sink             config_wr
);

	// ---- register file ----
	tbf_pkg::cfg_t cfg_q;

	assign config_wr.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= tbf_pkg::MODE_HEADLESS;
			cfg_q.data_length <= '0;
			cfg_q.start_value <= '0;
			cfg_q.autostart   <= 1'b0;
			cfg_q.name_low    <= 64'h2020_2020_2020_2020;
			cfg_q.name_high   <= 16'h2020;
		end else if (config_wr.valid) begin
			unique case (config_wr.index)
				tbf_pkg::REG_MODE:      cfg_q.mode        <= config_wr.data[1:0];
				tbf_pkg::REG_LENGTH:    cfg_q.data_length <= config_wr.data[15:0];
				tbf_pkg::REG_START:     cfg_q.start_value <= config_wr.data[15:0];
				tbf_pkg::REG_AUTOSTART: cfg_q.autostart   <= config_wr.data[0];
				tbf_pkg::REG_NAME_LO:   cfg_q.name_low    <= config_wr.data;
				tbf_pkg::REG_NAME_HI:   cfg_q.name_high   <= config_wr.data[15:0];
				default: ;
			endcase
		end
	end

	// ---- block state ----
	logic        open_q;
	logic [15:0] seen_q;
	logic [7:0]  xor_q;

	// ---- item stage ----
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [4:0]  idx_s1;
	logic [4:0]  last_s1;
	logic [1:0]  status_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  sum_s1;

	// ---- result register ----
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic [1:0]  out_status_q;

	logic        accept;
	logic        emit;
	logic        run_done;
	logic        flagged;
	logic        too_long;
	logic [15:0] seen_next;

	// plan of the incoming item
	logic [1:0]  plan_kind;
	logic [4:0]  plan_first;
	logic [4:0]  plan_last;
	logic [1:0]  plan_status;
	logic        nxt_open;
	logic [15:0] nxt_seen;
	logic [7:0]  nxt_xor;

	logic [7:0]  prefix_byte;
	logic [7:0]  sel_byte;

	// advance the run whenever the result register is free or being drained
	assign emit     = valid_s1 && (!out_valid_q || results.ready);
	assign run_done = emit && (idx_s1 == last_s1);
	assign items.ready = !valid_s1 || run_done;
	assign accept   = items.valid && items.ready;

	assign flagged   = (cfg_q.mode != tbf_pkg::MODE_RAW);
	assign too_long  = flagged ? ({1'b0, cfg_q.data_length} > tbf_pkg::LEN_MAX_FLAG)
	                           : ({1'b0, cfg_q.data_length} > tbf_pkg::LEN_MAX_RAW);
	assign seen_next = seen_q + 16'd1;

	always_comb begin
		plan_kind   = tbf_pkg::KIND_FAIL;
		plan_first  = '0;
		plan_last   = '0;
		plan_status = tbf_pkg::ST_OK;
		nxt_open    = open_q;
		nxt_seen    = seen_q;
		nxt_xor     = xor_q;
		if (items.action == tbf_pkg::ACT_START) begin
			// start always abandons the old block
			nxt_open = !too_long;
			nxt_seen = '0;
			nxt_xor  = (flagged && !too_long) ? tbf_pkg::FLAG_DATA : 8'd0;
			if (too_long) begin
				plan_status = tbf_pkg::ST_TOO_LONG;
			end else begin
				plan_kind  = tbf_pkg::KIND_START;
				plan_first = (cfg_q.mode == tbf_pkg::MODE_BASIC || cfg_q.mode == tbf_pkg::MODE_CODE)
				             ? tbf_pkg::POS_HDR_LEN_LO : tbf_pkg::POS_LEN_LO;
				if (!flagged) begin
					plan_last = tbf_pkg::POS_LEN_HI;
				end else if (cfg_q.data_length == '0) begin
					plan_last = tbf_pkg::POS_EMPTY_SUM;
				end else begin
					plan_last = tbf_pkg::POS_FLAG;
				end
			end
		end else begin
			priority if (!open_q) begin
				plan_status = tbf_pkg::ST_EARLY;
			end else if (seen_q >= cfg_q.data_length) begin
				plan_status = tbf_pkg::ST_SURPLUS;
			end else begin
				plan_kind = tbf_pkg::KIND_DATA;
				nxt_seen  = seen_next;
				if (flagged) begin
					nxt_xor = xor_q ^ items.data_byte;
				end
				// checksum beat follows the last byte of a flagged block
				plan_last = (flagged && seen_next == cfg_q.data_length) ? 5'd1 : 5'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			seen_q <= '0;
			xor_q  <= '0;
		end else if (accept) begin
			open_q <= nxt_open;
			seen_q <= nxt_seen;
			xor_q  <= nxt_xor;
		end
	end

	// hold the item and step through its run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			idx_s1   <= plan_first;
		end else if (run_done) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			idx_s1 <= idx_s1 + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= plan_kind;
			last_s1   <= plan_last;
			status_s1 <= plan_status;
			byte_s1   <= items.data_byte;
			sum_s1    <= nxt_xor;
		end
	end

	tbf_prefix u_prefix (
		.cfg   (cfg_q),
		.pos   (idx_s1),
		.pbyte (prefix_byte)
	);

	always_comb begin
		unique case (kind_s1)
			tbf_pkg::KIND_START: sel_byte = prefix_byte;
			tbf_pkg::KIND_DATA:  sel_byte = (idx_s1 == '0) ? byte_s1 : sum_s1;
			default:             sel_byte = 8'd0;
		endcase
	end

	// result register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= sel_byte;
			out_last_q   <= (idx_s1 == last_s1);
			out_status_q <= status_s1;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.out_byte    = out_byte_q;
	assign results.last_of_run = out_last_q;
	assign results.status      = out_status_q;

	// ---- checks ----
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> items.ready)
		else $error("item stage empty but input not ready");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item did not reach the item stage");

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> idx_s1 <= last_s1)
		else $error("run index past its last beat");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.status != tbf_pkg::ST_OK) |-> results.last_of_run)
		else $error("error beat not marked last of run");

	a_emit_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(run_done && !accept) |=> !valid_s1)
		else $error("item stage still busy after its last beat");

endmodule

`default_nettype wire
